// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int PRIO_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;
  localparam int STAT_W   = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_MATCHED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FRONT    = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } entry_t;

  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic                      any_match;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } cmd_t;

  typedef struct packed {
    logic shift;
    logic match;
    logic first;
  } flags_t;

endpackage

// ===== sv/spq_cell.sv =====
module spq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::entry_t left_q,
  input  spq_pkg::flags_t left_flags,
  input  spq_pkg::entry_t right_q,
  output spq_pkg::entry_t q,
  output spq_pkg::flags_t flags
);

  logic                              valid_r;
  logic                              valid_nxt;
  logic signed [spq_pkg::VALUE_W-1:0] value_r;
  logic signed [spq_pkg::VALUE_W-1:0] value_nxt;
  logic [spq_pkg::PRIO_W-1:0]         prio_r;
  logic [spq_pkg::PRIO_W-1:0]         prio_nxt;
  logic                              take_right;

  assign flags.shift = !valid_r || (cmd.prio < prio_r);
  assign flags.match = valid_r && (prio_r == cmd.prio);
  assign flags.first = flags.match && !left_flags.match;
  assign take_right  = !cmd.any_match || !valid_r || (prio_r >= cmd.prio);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (cmd.ins && flags.shift) begin
      if (left_flags.shift) begin
        valid_nxt = left_q.valid;
        value_nxt = left_q.value;
        prio_nxt  = left_q.prio;
      end else begin
        valid_nxt = 1'b1;
        value_nxt = cmd.value;
        prio_nxt  = cmd.prio;
      end
    end else if (cmd.del && take_right) begin
      valid_nxt = right_q.valid;
      value_nxt = right_q.value;
      prio_nxt  = right_q.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign q.valid = valid_r;
  assign q.value = value_r;
  assign q.prio  = prio_r;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Output: a result beat appears in the cycle after its input beat is accepted.
// Throughput: one op per cycle unless stalled; every cell of the chain compares
// and moves its entry in the same cycle; the output register takes the result.
// Reset: synchronous active-low rst_n empties the queue and drops any pending
// result beat; stored values and priorities are not cleared.
module sorted_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic signed [31:0]                in_item_value,
  input  logic [7:0]                        in_item_priority,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_removed_value,
  output logic [spq_pkg::STAT_W-1:0]        out_status,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy
);

  `include "assert_macros.svh"

  spq_pkg::entry_t cell_q     [spq_pkg::CAPACITY];
  spq_pkg::flags_t cell_flags [spq_pkg::CAPACITY];
  spq_pkg::cmd_t   cmd;

  logic [spq_pkg::CNT_W-1:0]          count_r;
  logic [spq_pkg::CNT_W-1:0]          count_nxt;
  logic                               out_valid_r;
  logic signed [spq_pkg::VALUE_W-1:0] removed_r;
  logic signed [spq_pkg::VALUE_W-1:0] removed_nxt;
  logic [spq_pkg::STAT_W-1:0]         status_r;
  logic [spq_pkg::STAT_W-1:0]         status_nxt;
  logic [spq_pkg::CAPACITY-1:0]       valid_vec;
  logic [spq_pkg::CAPACITY-1:0]       match_vec;
  logic signed [spq_pkg::VALUE_W-1:0] match_value;
  logic                               in_fire;
  logic                               full;
  logic                               empty;
  logic                               del_empty;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign full     = (count_r == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign empty    = (count_r == '0);
  assign del_empty = in_fire && (in_op == spq_pkg::OP_DELETE) && empty;

  always_comb begin
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      valid_vec[i] = cell_q[i].valid;
      match_vec[i] = cell_flags[i].match;
    end
  end

  assign cmd.ins       = in_fire && (in_op == spq_pkg::OP_INSERT) && !full;
  assign cmd.del       = in_fire && (in_op == spq_pkg::OP_DELETE) && !empty;
  assign cmd.any_match = |match_vec;
  assign cmd.value     = in_item_value;
  assign cmd.prio      = spq_pkg::PRIO_W'(in_item_priority);

  for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_q;
    spq_pkg::flags_t left_flags;
    spq_pkg::entry_t right_q;

    if (i == 0) begin : g_head
      assign left_q     = '0;
      assign left_flags = '0;
    end else begin : g_body
      assign left_q     = cell_q[i-1];
      assign left_flags = cell_flags[i-1];
    end

    if (i == spq_pkg::CAPACITY - 1) begin : g_tail
      assign right_q = '0;
    end else begin : g_next
      assign right_q = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_q     (left_q),
      .left_flags (left_flags),
      .right_q    (right_q),
      .q          (cell_q[i]),
      .flags      (cell_flags[i])
    );
  end

  always_comb begin
    match_value = '0;
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      if (cell_flags[i].first) begin
        match_value = match_value | cell_q[i].value;
      end
    end
  end

  always_comb begin
    count_nxt   = count_r;
    removed_nxt = '0;
    status_nxt  = spq_pkg::ST_INSERTED;
    if (in_op == spq_pkg::OP_INSERT) begin
      if (full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else if (cmd.any_match) begin
        status_nxt  = spq_pkg::ST_MATCHED;
        removed_nxt = match_value;
        count_nxt   = count_r - 1'b1;
      end else begin
        status_nxt  = spq_pkg::ST_FRONT;
        removed_nxt = cell_q[0].value;
        count_nxt   = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      removed_r <= removed_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = removed_r;
  assign out_status        = status_r;
  assign out_occupancy     = spq_pkg::OCC_W'(count_r);

  `SPQ_ASSERT(a_count_bound, count_r <= spq_pkg::CNT_W'(spq_pkg::CAPACITY), "count too high")
  `SPQ_ASSERT(a_valid_count, $countones(valid_vec) == int'(count_r), "valid cells off count")
  `SPQ_ASSERT(a_empty_status, del_empty |=> out_status == spq_pkg::ST_EMPTY, "empty not flagged")
  `SPQ_ASSERT(a_insert_grows, cmd.ins |=> (count_r == $past(count_r) + 1'b1), "insert lost")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int BLOCK_ITEMS  = 100;
  localparam int SETTLE       = 5;

  typedef struct packed {
    logic signed [spq_pkg::VALUE_W-1:0] removed;
    logic [spq_pkg::STAT_W-1:0]         status;
    logic [spq_pkg::OCC_W-1:0]          occ;
  } reply_t;

  typedef struct {
    logic                               op;
    logic signed [spq_pkg::VALUE_W-1:0] value;
    logic [spq_pkg::PRIO_W-1:0]         prio;
    bit                                 fixed;
    reply_t                             want;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_op = spq_pkg::OP_INSERT;
  logic signed [31:0]         in_item_value = '0;
  logic [7:0]                 in_item_priority = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [31:0]         out_removed_value;
  logic [spq_pkg::STAT_W-1:0] out_status;
  logic [spq_pkg::OCC_W-1:0]  out_occupancy;

  sorted_priority_queue u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_item_value     (in_item_value),
    .in_item_priority  (in_item_priority),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_occupancy     (out_occupancy)
  );

  always #5 clk = ~clk;

  logic signed [spq_pkg::VALUE_W-1:0] held_value [spq_pkg::CAPACITY];
  logic [spq_pkg::PRIO_W-1:0]         held_prio  [spq_pkg::CAPACITY];
  int                                 held_count = 0;

  reply_t answer_q [$];
  reply_t seen_want;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int sent_count = 0;
  int status_seen [5] = '{0, 0, 0, 0, 0};

  row_t dir_rows [24] = '{
    '{spq_pkg::OP_DELETE, 32'sd0, 8'd0, 1'b1, '{32'sd0, spq_pkg::ST_EMPTY, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sh7FFFFFFF, 8'd255, 1'b1, '{32'sd0, spq_pkg::ST_INSERTED, 5'd1}},
    '{spq_pkg::OP_INSERT, 32'sh80000000, 8'd0, 1'b1, '{32'sd0, spq_pkg::ST_INSERTED, 5'd2}},
    '{spq_pkg::OP_DELETE, 32'sd0, 8'd255, 1'b1,
      '{32'sh7FFFFFFF, spq_pkg::ST_MATCHED, 5'd1}},
    '{spq_pkg::OP_DELETE, 32'sd0, 8'd5, 1'b1, '{32'sh80000000, spq_pkg::ST_FRONT, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd11, 8'd3, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, -32'sd22, 8'd3, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd33, 8'd7, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd44, 8'd1, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd55, 8'd255, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd66, 8'd0, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd77, 8'd3, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd88, 8'd128, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, -32'sd99, 8'd7, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd110, 8'd64, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd121, 8'd0, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd132, 8'd200, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd143, 8'd3, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sh5A5A5A5A, 8'd16, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, -32'sd1, 8'd255, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sd0, 8'd9, 1'b0, '{32'sd0, spq_pkg::ST_INSERTED, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'sh12345678, 8'd42, 1'b1, '{32'sd0, spq_pkg::ST_FULL, 5'd16}},
    '{spq_pkg::OP_DELETE, 32'sd0, 8'd3, 1'b0, '{32'sd0, spq_pkg::ST_MATCHED, 5'd0}},
    '{spq_pkg::OP_DELETE, 32'sd0, 8'd2, 1'b0, '{32'sd0, spq_pkg::ST_FRONT, 5'd0}}
  };

  function automatic reply_t apply_op(input logic op,
                                      input logic signed [spq_pkg::VALUE_W-1:0] val,
                                      input logic [spq_pkg::PRIO_W-1:0] prio);
    reply_t r;
    int     pos;
    bit     hit;
    r.removed = '0;
    pos = 0;
    hit = 1'b0;
    if (op == spq_pkg::OP_INSERT) begin
      if (held_count >= spq_pkg::CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = held_count;
        for (int i = 0; i < held_count; i++) begin
          if (!hit && prio < held_prio[i]) begin
            pos = i;
            hit = 1'b1;
          end
        end
        for (int i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[pos] = val;
        held_prio[pos]  = prio;
        held_count++;
        r.status = spq_pkg::ST_INSERTED;
      end
    end else begin
      if (held_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        for (int i = 0; i < held_count; i++) begin
          if (!hit && held_prio[i] == prio) begin
            pos = i;
            hit = 1'b1;
          end
        end
        r.removed = held_value[pos];
        for (int i = pos; i + 1 < held_count; i++) begin
          held_value[i] = held_value[i+1];
          held_prio[i]  = held_prio[i+1];
        end
        held_count--;
        r.status = hit ? spq_pkg::ST_MATCHED : spq_pkg::ST_FRONT;
      end
    end
    r.occ = held_count[spq_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic send_beat(input logic op, input logic signed [31:0] val,
                           input logic [7:0] prio, input bit fixed, input reply_t want);
    reply_t got;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_item_value    <= val;
    in_item_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = apply_op(op, val, prio);
    answer_q.push_back(fixed ? want : got);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input reply_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected value %0d status %0d occupancy %0d, got %0d %0d %0d",
               what, want.removed, want.status, want.occ,
               out_removed_value, out_status, out_occupancy);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected beat", '0);
      end else begin
        seen_want = answer_q.pop_front();
        if (out_status < 5) status_seen[out_status]++;
        if (out_removed_value !== seen_want.removed || out_status !== seen_want.status ||
            out_occupancy !== seen_want.occ) begin
          report_mismatch("field", seen_want);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic                      op;
    logic signed [31:0]        val;
    logic [7:0]                prio;
    int                        ins_pct;
    int                        blk;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_beat(dir_rows[k].op, dir_rows[k].value, dir_rows[k].prio,
                dir_rows[k].fixed, dir_rows[k].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) begin
        wait_drained();
        blk = n / BLOCK_ITEMS;
        case (blk % 4)
          0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
          1: begin snd_idle_pct = 66; rcv_stall_pct = 0;  end
          2: begin snd_idle_pct = 0;  rcv_stall_pct = 66; end
          default: begin snd_idle_pct = 24; rcv_stall_pct = 24; end
        endcase
        ins_pct = (blk % 3 == 1) ? 80 : (blk % 3 == 2) ? 25 : 55;
      end
      op = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_DELETE;
      case ($urandom_range(0, 9))
        0: val = 32'sh7FFFFFFF;
        1: val = 32'sh80000000;
        default: val = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: prio = 8'($urandom_range(0, 3));
        3: prio = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        default: prio = 8'($urandom_range(0, 255));
      endcase
      if (op == spq_pkg::OP_DELETE && held_count > 0 && $urandom_range(0, 99) < 65) begin
        prio = held_prio[$urandom_range(0, held_count - 1)];
      end
      send_beat(op, val, prio, 1'b0, '0);
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (answer_q.size() != 0) mismatches++;

    $display("ran %0d operations under four idle/stall mixes: %0d inserts, %0d matched deletes,",
             sent_count, status_seen[spq_pkg::ST_INSERTED],
             status_seen[spq_pkg::ST_MATCHED]);
    $display("%0d front deletes, %0d deletes on empty, %0d rejected when full, %0d mismatches",
             status_seen[spq_pkg::ST_FRONT], status_seen[spq_pkg::ST_EMPTY],
             status_seen[spq_pkg::ST_FULL], mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
